// ===== rtl/bam_pkg.sv =====
// types, codes and sizing constants for the block allocation map
// no dependencies; imported by block_allocation_map and its checker
package bam_pkg;

  localparam int BAM_MAX_BLOCKS = 256;
  localparam int WORD_W         = 32;
  localparam int LOG_W          = 5;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_MARK  = 2'd1;
  localparam logic [1:0] REQ_ALLOC = 2'd2;

  localparam logic CFG_TOTAL    = 1'b0;
  localparam logic CFG_RESERVED = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_INVALID = 3'd2,
    ST_OVERLAP = 3'd3,
    ST_FULL    = 3'd4
  } bam_status_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] block_number;
  } bam_req_t;

  typedef struct packed {
    bam_status_t status;
    logic [7:0]  allocated_block;
    logic [8:0]  free_count;
    logic        invalid_seen;
    logic        overlap_seen;
  } bam_rsp_t;

endpackage

// ===== rtl/block_allocation_map.sv =====
// mark reads the block's map word and then sets its bit; clear writes every map word in turn;
//   allocate scans one 32-bit map word per cycle from the map memory
// throughput: one item at a time; busy stays high until its result strobe
// the map memory has one write port and one read port, one word each per cycle
// reset (sync, rst_n low): map words read as empty via per-word valid bits,
//   free count 0, pointer 2, flags clear, total 256, reserved 2; results cannot be stalled
module block_allocation_map
  import bam_pkg::*;
#(
  parameter int MAX_BLOCKS = BAM_MAX_BLOCKS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  bam_req_t in_item,
  output logic     out_valid,
  output bam_rsp_t out_item,
  input  logic     cfg_we,
  input  logic     cfg_index,
  input  logic [8:0] cfg_wdata
);

  localparam int WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WIDX  = (WORDS > 1) ? $clog2(WORDS) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_EVAL  = 4'b0100,
    S_CLEAR = 4'b1000
  } state_t;

  function automatic logic [WIDX-1:0] word_of(input logic [8:0] x);
    logic [8:0] sh;
    sh = x >> LOG_W;
    return sh[WIDX-1:0];
  endfunction

  state_t        state_r, state_nxt;
  bam_req_t      req_r, req_nxt;
  logic [8:0]    total_r;
  logic [7:0]    rsv_r;
  logic [WIDX-1:0] word_r, word_nxt;
  logic          phase_r, phase_nxt;
  logic [7:0]    sptr_r, sptr_nxt;
  logic [7:0]    ptr_r, ptr_nxt;
  logic [8:0]    free_r, free_nxt;
  logic          inv_r, inv_nxt;
  logic          ovl_r, ovl_nxt;
  logic          out_valid_r, out_valid_nxt;
  bam_rsp_t      out_item_r, out_item_nxt;

  // map memory
  logic [WORD_W-1:0] mem [WORDS];
  logic [WORDS-1:0]  vld_r;
  logic [WORD_W-1:0] rd_data_r;
  logic              rd_vld_r;
  logic [WIDX-1:0]   raddr;
  logic              mem_we;
  logic [WORD_W-1:0] wdata;

  logic [8:0]  eff_t;
  logic [7:0]  eff_r;
  logic        vol_full;
  logic [8:0]  base;
  logic [WORD_W-1:0] rd_word;
  logic [WORD_W-1:0] cand;
  logic [LOG_W-1:0]  sel;
  logic        any;
  logic [8:0]  lo, hi, lim, idx, blk9, gnt, pnext;
  logic [WORD_W-1:0] clr_mask;
  logic        done;
  bam_status_t rsp_status;
  logic [7:0]  rsp_block;
  logic [7:0]  s_ptr;
  logic [WIDX-1:0] nxt_word;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[word_r] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[raddr];
      if (mem_we) begin
        vld_r[word_r] <= 1'b1;
      end
    end
  end

  assign eff_t    = (total_r > 9'(MAX_BLOCKS)) ? 9'(MAX_BLOCKS) : total_r;
  assign eff_r    = (rsv_r == 8'd0) ? 8'd1 : rsv_r;
  assign vol_full = {1'b0, eff_r} >= eff_t;
  assign base     = 9'(word_r) << LOG_W;
  assign rd_word  = rd_vld_r ? rd_data_r : '0;
  assign blk9     = {1'b0, req_r.block_number};
  assign lim      = vol_full ? eff_t : {1'b0, eff_r};
  assign lo       = phase_r ? {1'b0, eff_r} : {1'b0, sptr_r};
  assign hi       = phase_r ? {1'b0, sptr_r} : eff_t;

  // free positions in the current word that lie inside the search window
  always_comb begin
    logic [8:0] bi;
    for (int j = 0; j < WORD_W; j++) begin
      bi          = base + 9'(j);
      cand[j]     = !rd_word[j] && (bi >= lo) && (bi < hi);
      clr_mask[j] = bi < lim;
    end
  end

  always_comb begin
    any = 1'b0;
    sel = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (cand[j]) begin
        any = 1'b1;
        sel = LOG_W'(j);
      end
    end
  end

  assign gnt   = base + 9'(sel);
  assign pnext = gnt + 9'd1;
  assign idx   = {1'b0, sptr_r} - 9'd1;
  assign s_ptr = (ptr_r < eff_r || {1'b0, ptr_r} >= eff_t) ? eff_r : ptr_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    word_nxt      = word_r;
    phase_nxt     = phase_r;
    sptr_nxt      = sptr_r;
    ptr_nxt       = ptr_r;
    free_nxt      = free_r;
    inv_nxt       = inv_r;
    ovl_nxt       = ovl_r;
    raddr         = word_r;
    mem_we        = 1'b0;
    wdata         = rd_word;
    done          = 1'b0;
    rsp_status    = ST_OK;
    rsp_block     = 8'd0;
    nxt_word      = word_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_item;
          state_nxt = S_START;
        end
      end
      S_START: begin
        case (req_r.req_type)
          REQ_CLEAR: begin
            word_nxt  = '0;
            state_nxt = S_CLEAR;
          end
          REQ_MARK: begin
            if (req_r.block_number == 8'd0) begin
              done       = 1'b1;
              rsp_status = ST_ZERO;
            end else if (req_r.block_number < eff_r || blk9 >= eff_t) begin
              inv_nxt    = 1'b1;
              done       = 1'b1;
              rsp_status = ST_INVALID;
            end else begin
              raddr     = word_of(blk9);
              word_nxt  = word_of(blk9);
              state_nxt = S_EVAL;
            end
          end
          REQ_ALLOC: begin
            if (vol_full) begin
              done       = 1'b1;
              rsp_status = ST_FULL;
            end else begin
              sptr_nxt  = s_ptr;
              phase_nxt = 1'b0;
              raddr     = word_of({1'b0, s_ptr});
              word_nxt  = word_of({1'b0, s_ptr});
              state_nxt = S_EVAL;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      S_EVAL: begin
        if (req_r.req_type == REQ_MARK) begin
          if (rd_word[req_r.block_number[LOG_W-1:0]]) begin
            ovl_nxt    = 1'b1;
            rsp_status = ST_OVERLAP;
          end else begin
            mem_we   = 1'b1;
            wdata    = rd_word | (WORD_W'(1) << req_r.block_number[LOG_W-1:0]);
            free_nxt = (free_r == 9'd0) ? 9'd0 : free_r - 9'd1;
          end
          done = 1'b1;
        end else if (any) begin
          mem_we    = 1'b1;
          wdata     = rd_word | (WORD_W'(1) << sel);
          free_nxt  = (free_r == 9'd0) ? 9'd0 : free_r - 9'd1;
          ptr_nxt   = (pnext >= eff_t) ? eff_r : pnext[7:0];
          rsp_block = gnt[7:0];
          done      = 1'b1;
        end else if (!phase_r) begin
          // end of the upper stretch: wrap to the first unreserved block
          if (word_r == word_of(eff_t - 9'd1)) begin
            if (sptr_r == eff_r) begin
              done       = 1'b1;
              rsp_status = ST_FULL;
            end else begin
              phase_nxt = 1'b1;
              nxt_word  = word_of({1'b0, eff_r});
            end
          end else begin
            nxt_word = word_r + WIDX'(1);
          end
        end else begin
          if (word_r == word_of(idx)) begin
            done       = 1'b1;
            rsp_status = ST_FULL;
          end else begin
            nxt_word = word_r + WIDX'(1);
          end
        end
        if (!done) begin
          raddr    = nxt_word;
          word_nxt = nxt_word;
        end
      end
      S_CLEAR: begin
        mem_we = 1'b1;
        wdata  = clr_mask;
        if (word_r == WIDX'(WORDS - 1)) begin
          free_nxt = vol_full ? 9'd0 : eff_t - {1'b0, eff_r};
          inv_nxt  = 1'b0;
          ovl_nxt  = 1'b0;
          ptr_nxt  = eff_r;
          done     = 1'b1;
        end else begin
          word_nxt = word_r + WIDX'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (done) begin
      state_nxt = S_IDLE;
    end
    out_valid_nxt                = done;
    out_item_nxt.status          = rsp_status;
    out_item_nxt.allocated_block = rsp_block;
    out_item_nxt.free_count      = free_nxt;
    out_item_nxt.invalid_seen    = inv_nxt;
    out_item_nxt.overlap_seen    = ovl_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= 9'd256;
      rsv_r       <= 8'd2;
      ptr_r       <= 8'd2;
      free_r      <= 9'd0;
      inv_r       <= 1'b0;
      ovl_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      free_r      <= free_nxt;
      inv_r       <= inv_nxt;
      ovl_r       <= ovl_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == CFG_TOTAL) begin
        total_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_RESERVED) begin
        rsv_r <= cfg_wdata[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    word_r     <= word_nxt;
    phase_r    <= phase_nxt;
    sptr_r     <= sptr_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/bam_checker.sv =====
// port-level checks for block_allocation_map
// depends on bam_pkg; bound to the top level at the end of this file
module bam_checker
  import bam_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input bam_rsp_t out_item
);

  // an accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // busy only drops when the item's result shows up
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in a row");

  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.allocated_block != 8'd0 |-> out_item.status == ST_OK)
    else $error("granted block with error status");

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.free_count <= 9'd256)
    else $error("free count out of range");

endmodule

bind block_allocation_map bam_checker u_bam_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
